>>> hdl/ptt_pkg.sv
// Shared types, widths and codes for the pre-integrated transfer table.
package ptt_pkg;

    // Sizes
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int IDX_W           = 8;
    localparam int COLOR_W         = 8;
    localparam int OPAC_W          = 16;
    localparam int CFG_W           = 9;
    localparam int SUM_W           = 64;
    localparam int TERM_W          = 27;
    localparam int ALPHA_TERM_W    = 17;
    localparam int DIV_W           = 19;
    localparam int Q_W             = 16;

    // Constants
    localparam logic [CFG_W-1:0] CFG_RESET       = 9'd256;
    localparam int               COLOR_DIV_SCALE = 1530;   // six times full-scale colour
    localparam int               ALPHA_DIV_SCALE = 2;
    localparam int               COLOR_FULL      = 255;

    // Function codes of an input transaction
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    // One table entry: prefix sums and the raw entry as loaded
    typedef struct packed {
        logic [SUM_W-1:0]   sum_red;
        logic [SUM_W-1:0]   sum_green;
        logic [SUM_W-1:0]   sum_blue;
        logic [SUM_W-1:0]   sum_alpha;
        logic [COLOR_W-1:0] raw_red;
        logic [COLOR_W-1:0] raw_green;
        logic [COLOR_W-1:0] raw_blue;
        logic [OPAC_W-1:0]  raw_opacity;
    } ram_word_t;

    // Accumulator request and response
    typedef struct packed {
        logic               start;
        logic               first;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [OPAC_W-1:0]  opacity;
    } ld_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [SUM_W-1:0] sum_alpha;
    } ld_rsp_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hdl/preintegrated_transfer_table.sv
// Pre-integrated transfer table: loads entries, answers front/back RGBA queries.
//
// Input channel (item_valid / item_stall): func selects a load or a query. A load
// writes one entry with its trapezoid prefix sums; the user must send loads in
// index order, which the block does not enforce, and index zero restarts the
// sums. A load gives no result; a load with an index out of range is dropped.
// A query reads the prefix sums at both indices and returns one result on the
// output channel (result_valid / result_stall) after two memory reads and four
// channel quotients on the one shared divider. A query with an index out of
// range returns with status set and zero colour. One transaction is worked on at
// a time; the next is taken as soon as the current one has finished, even
// while its result still waits in the output register under result_stall.
// Configuration (cfg_valid / cfg_ready) sets entries_in_use; it is always
// ready. Reset clears the running sums, the previous entry, the output valid
// and sets entries_in_use to 256. The table memory is not cleared: an entry
// must be loaded before it is queried.
module preintegrated_transfer_table #(
    parameter int MAX_ENTRIES = ptt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          func,
    input  logic [ptt_pkg::IDX_W-1:0]     entry_index,
    input  logic [ptt_pkg::COLOR_W-1:0]   entry_red,
    input  logic [ptt_pkg::COLOR_W-1:0]   entry_green,
    input  logic [ptt_pkg::COLOR_W-1:0]   entry_blue,
    input  logic [ptt_pkg::OPAC_W-1:0]    entry_opacity,
    input  logic [ptt_pkg::IDX_W-1:0]     front_index,
    input  logic [ptt_pkg::IDX_W-1:0]     back_index,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ptt_pkg::Q_W-1:0]       out_red,
    output logic [ptt_pkg::Q_W-1:0]       out_green,
    output logic [ptt_pkg::Q_W-1:0]       out_blue,
    output logic [ptt_pkg::Q_W-1:0]       out_alpha,
    output logic                          status
);

    localparam int AW = $clog2(MAX_ENTRIES);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_LOAD_W = 3'd2;
    localparam logic [2:0] ST_RD_LO  = 3'd3;
    localparam logic [2:0] ST_RD_HI  = 3'd4;
    localparam logic [2:0] ST_CH     = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0]                  state_reg;
    logic [ptt_pkg::CFG_W-1:0]   entries_reg;
    logic [1:0]                  ch_reg;
    logic                        err_reg;
    logic                        same_reg;
    logic [ptt_pkg::IDX_W-1:0]   idx_reg;
    logic [ptt_pkg::IDX_W-1:0]   lo_reg;
    logic [ptt_pkg::IDX_W-1:0]   hi_reg;
    logic [ptt_pkg::COLOR_W-1:0] red_reg;
    logic [ptt_pkg::COLOR_W-1:0] green_reg;
    logic [ptt_pkg::COLOR_W-1:0] blue_reg;
    logic [ptt_pkg::OPAC_W-1:0]  opac_reg;
    ptt_pkg::ram_word_t          lo_word_reg;
    ptt_pkg::ram_word_t          hi_word_reg;
    logic [ptt_pkg::Q_W-1:0]     q_red_reg;
    logic [ptt_pkg::Q_W-1:0]     q_green_reg;
    logic [ptt_pkg::Q_W-1:0]     q_blue_reg;
    logic [ptt_pkg::Q_W-1:0]     q_alpha_reg;
    logic                        result_valid_reg;
    logic [ptt_pkg::Q_W-1:0]     out_red_reg;
    logic [ptt_pkg::Q_W-1:0]     out_green_reg;
    logic [ptt_pkg::Q_W-1:0]     out_blue_reg;
    logic [ptt_pkg::Q_W-1:0]     out_alpha_reg;
    logic                        status_reg;

    logic                        item_take;
    logic                        load_ok;
    logic                        query_ok;
    logic [ptt_pkg::IDX_W-1:0]   in_lo;
    logic [ptt_pkg::IDX_W-1:0]   in_hi;
    logic                        out_free;
    logic                        emit_fire;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    ptt_pkg::ram_word_t          ram_wdata;
    ptt_pkg::ram_word_t          ram_rdata;

    ptt_pkg::ld_req_t            ld_req;
    ptt_pkg::ld_rsp_t            ld_rsp;
    ptt_pkg::div_req_t           div_req;
    ptt_pkg::div_rsp_t           div_rsp;

    logic [ptt_pkg::COLOR_W-1:0] sel_color;
    logic [ptt_pkg::SUM_W-1:0]   sel_near;
    logic [ptt_pkg::SUM_W-1:0]   sel_far;
    logic [ptt_pkg::OPAC_W+ptt_pkg::COLOR_W-1:0] same_prod;
    logic [ptt_pkg::IDX_W-1:0]   span;
    logic [ptt_pkg::DIV_W-1:0]   color_div;
    logic [ptt_pkg::DIV_W-1:0]   alpha_div;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ptt_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entries_reg <= cfg_data;
        end
    end

    // Range checks against min(entries_in_use, MAX_ENTRIES)
    assign load_ok  = ({1'b0, entry_index} < entries_reg) &&
                      (32'(entry_index) < MAX_ENTRIES);
    assign query_ok = ({1'b0, front_index} < entries_reg) &&
                      ({1'b0, back_index} < entries_reg) &&
                      (32'(front_index) < MAX_ENTRIES) &&
                      (32'(back_index) < MAX_ENTRIES);
    assign in_lo    = (front_index < back_index) ? front_index : back_index;
    assign in_hi    = (front_index < back_index) ? back_index : front_index;

    assign item_stall = state_reg != ST_IDLE;
    assign item_take  = item_valid && !item_stall;

    // Output register frees when its transaction is taken
    assign out_free  = !result_valid_reg || !result_stall;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    // Table memory: one read port for both ends, written once per load
    assign ram_raddr = (state_reg == ST_IDLE) ? AW'(in_lo) : AW'(hi_reg);
    assign ram_we    = (state_reg == ST_LOAD_W) && ld_rsp.done;
    assign ram_waddr = AW'(idx_reg);

    always_comb
    begin
        ram_wdata.sum_red     = ld_rsp.sum_red;
        ram_wdata.sum_green   = ld_rsp.sum_green;
        ram_wdata.sum_blue    = ld_rsp.sum_blue;
        ram_wdata.sum_alpha   = ld_rsp.sum_alpha;
        ram_wdata.raw_red     = red_reg;
        ram_wdata.raw_green   = green_reg;
        ram_wdata.raw_blue    = blue_reg;
        ram_wdata.raw_opacity = opac_reg;
    end

    ptt_ram #(
        .WIDTH ($bits(ptt_pkg::ram_word_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Accumulator
    always_comb
    begin
        ld_req.start   = state_reg == ST_LOAD;
        ld_req.first   = idx_reg == '0;
        ld_req.red     = red_reg;
        ld_req.green   = green_reg;
        ld_req.blue    = blue_reg;
        ld_req.opacity = opac_reg;
    end

    ptt_load u_load (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ld_req),
        .rsp   (ld_rsp)
    );

    // Select the operands of the current channel
    always_comb
    begin
        case (ch_reg)
            ptt_pkg::CH_RED:
            begin
                sel_color = lo_word_reg.raw_red;
                sel_near  = lo_word_reg.sum_red;
                sel_far   = hi_word_reg.sum_red;
            end
            ptt_pkg::CH_GREEN:
            begin
                sel_color = lo_word_reg.raw_green;
                sel_near  = lo_word_reg.sum_green;
                sel_far   = hi_word_reg.sum_green;
            end
            ptt_pkg::CH_BLUE:
            begin
                sel_color = lo_word_reg.raw_blue;
                sel_near  = lo_word_reg.sum_blue;
                sel_far   = hi_word_reg.sum_blue;
            end
            default:
            begin
                sel_color = ptt_pkg::COLOR_W'(1);
                sel_near  = lo_word_reg.sum_alpha;
                sel_far   = hi_word_reg.sum_alpha;
            end
        endcase
    end

    assign same_prod = lo_word_reg.raw_opacity * sel_color;
    assign span      = hi_reg - lo_reg;
    assign color_div = ptt_pkg::DIV_W'(span) * ptt_pkg::DIV_W'(ptt_pkg::COLOR_DIV_SCALE);
    assign alpha_div = ptt_pkg::DIV_W'(span) * ptt_pkg::DIV_W'(ptt_pkg::ALPHA_DIV_SCALE);

    // Divider request: equal ends divide weighted colour by full scale, alpha by one
    always_comb
    begin
        div_req.start = state_reg == ST_CH;
        if (same_reg)
        begin
            div_req.dividend = ptt_pkg::SUM_W'(same_prod);
            div_req.divisor  = (ch_reg == ptt_pkg::CH_ALPHA) ? ptt_pkg::DIV_W'(1)
                                                            : ptt_pkg::DIV_W'(ptt_pkg::COLOR_FULL);
        end
        else
        begin
            div_req.dividend = (sel_far < sel_near) ? '0 : sel_far - sel_near;
            div_req.divisor  = (ch_reg == ptt_pkg::CH_ALPHA) ? alpha_div : color_div;
        end
    end

    ptt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer: one transaction at a time, so table accesses never overlap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= ptt_pkg::CH_RED;
            err_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_take)
                    begin
                        if (func == ptt_pkg::FUNC_LOAD)
                        begin
                            if (load_ok)
                            begin
                                state_reg <= ST_LOAD;
                            end
                        end
                        else if (query_ok)
                        begin
                            err_reg   <= 1'b0;
                            state_reg <= ST_RD_LO;
                        end
                        else
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_LOAD_W;
                end
                ST_LOAD_W:
                begin
                    if (ld_rsp.done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RD_LO:
                begin
                    state_reg <= ST_RD_HI;
                end
                ST_RD_HI:
                begin
                    ch_reg    <= ptt_pkg::CH_RED;
                    state_reg <= ST_CH;
                end
                ST_CH:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (ch_reg == ptt_pkg::CH_ALPHA)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_CH;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Hold the transaction fields and the words read back
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            idx_reg   <= entry_index;
            red_reg   <= entry_red;
            green_reg <= entry_green;
            blue_reg  <= entry_blue;
            opac_reg  <= entry_opacity;
            lo_reg    <= in_lo;
            hi_reg    <= in_hi;
            same_reg  <= front_index == back_index;
        end
        if (state_reg == ST_RD_LO)
        begin
            lo_word_reg <= ram_rdata;
        end
        if (state_reg == ST_RD_HI)
        begin
            hi_word_reg <= ram_rdata;
        end
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            case (ch_reg)
                ptt_pkg::CH_RED:   q_red_reg   <= div_rsp.quotient;
                ptt_pkg::CH_GREEN: q_green_reg <= div_rsp.quotient;
                ptt_pkg::CH_BLUE:  q_blue_reg  <= div_rsp.quotient;
                default:           q_alpha_reg <= div_rsp.quotient;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_red_reg   <= err_reg ? '0 : q_red_reg;
            out_green_reg <= err_reg ? '0 : q_green_reg;
            out_blue_reg  <= err_reg ? '0 : q_blue_reg;
            out_alpha_reg <= err_reg ? '0 : q_alpha_reg;
            status_reg    <= err_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_red      = out_red_reg;
    assign out_green    = out_green_reg;
    assign out_blue     = out_blue_reg;
    assign out_alpha    = out_alpha_reg;
    assign status       = status_reg;

    // The divider is never restarted while it is still working
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Accumulator results arrive only while the sequencer waits for them
    a_load_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        ld_rsp.done |-> state_reg == ST_LOAD_W)
        else $error("accumulator result outside load wait");

    // Divider results arrive only while the sequencer waits for them
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider result outside divide wait");

    // A table write ends the load and frees the input channel
    a_write_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> state_reg == ST_IDLE)
        else $error("table write not followed by idle");

    // A result is only launched into a free output register
    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> !(result_valid && result_stall))
        else $error("pending result overwritten");

endmodule

>>> hdl/ptt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ptt_load.sv
// Trapezoid accumulator: previous entry, running prefix sums and the per-load terms.
module ptt_load (
    input  logic              clk,
    input  logic              rst_n,
    input  ptt_pkg::ld_req_t  req,
    output ptt_pkg::ld_rsp_t  rsp
);

    logic [ptt_pkg::COLOR_W-1:0]      prev_red_reg;
    logic [ptt_pkg::COLOR_W-1:0]      prev_green_reg;
    logic [ptt_pkg::COLOR_W-1:0]      prev_blue_reg;
    logic [ptt_pkg::OPAC_W-1:0]       prev_opac_reg;
    logic [ptt_pkg::TERM_W-1:0]       term_red_reg;
    logic [ptt_pkg::TERM_W-1:0]       term_green_reg;
    logic [ptt_pkg::TERM_W-1:0]       term_blue_reg;
    logic [ptt_pkg::ALPHA_TERM_W-1:0] term_alpha_reg;
    logic                             first_reg;
    logic                             pend_reg;
    logic                             done_reg;
    logic [ptt_pkg::SUM_W-1:0]        sum_red_reg;
    logic [ptt_pkg::SUM_W-1:0]        sum_green_reg;
    logic [ptt_pkg::SUM_W-1:0]        sum_blue_reg;
    logic [ptt_pkg::SUM_W-1:0]        sum_alpha_reg;

    // (a1+a0)(c1+c0) + a1*c1 + a0*c0
    function automatic logic [ptt_pkg::TERM_W-1:0] color_term(
        input logic [ptt_pkg::OPAC_W-1:0]  a0,
        input logic [ptt_pkg::COLOR_W-1:0] c0,
        input logic [ptt_pkg::OPAC_W-1:0]  a1,
        input logic [ptt_pkg::COLOR_W-1:0] c1
    );
        logic [ptt_pkg::OPAC_W:0]                      a_sum;
        logic [ptt_pkg::COLOR_W:0]                     c_sum;
        logic [ptt_pkg::OPAC_W+ptt_pkg::COLOR_W+1:0]   p_sum;
        logic [ptt_pkg::OPAC_W+ptt_pkg::COLOR_W-1:0]   p_new;
        logic [ptt_pkg::OPAC_W+ptt_pkg::COLOR_W-1:0]   p_old;
        a_sum = {1'b0, a0} + {1'b0, a1};
        c_sum = {1'b0, c0} + {1'b0, c1};
        p_sum = a_sum * c_sum;
        p_new = a1 * c1;
        p_old = a0 * c0;
        return {1'b0, p_sum} + {3'b0, p_new} + {3'b0, p_old};
    endfunction

    // Form the terms against the previous entry, then remember the new one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_red_reg   <= '0;
            prev_green_reg <= '0;
            prev_blue_reg  <= '0;
            prev_opac_reg  <= '0;
            pend_reg       <= 1'b0;
            first_reg      <= 1'b0;
        end
        else
        begin
            pend_reg <= req.start;
            if (req.start)
            begin
                first_reg      <= req.first;
                prev_red_reg   <= req.red;
                prev_green_reg <= req.green;
                prev_blue_reg  <= req.blue;
                prev_opac_reg  <= req.opacity;
            end
        end
    end

    // Term registers carry payload only
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            term_red_reg   <= color_term(prev_opac_reg, prev_red_reg, req.opacity, req.red);
            term_green_reg <= color_term(prev_opac_reg, prev_green_reg, req.opacity, req.green);
            term_blue_reg  <= color_term(prev_opac_reg, prev_blue_reg, req.opacity, req.blue);
            term_alpha_reg <= {1'b0, prev_opac_reg} + {1'b0, req.opacity};
        end
    end

    // Advance the running sums, or restart them at entry zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
            sum_alpha_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= pend_reg;
            if (pend_reg)
            begin
                if (first_reg)
                begin
                    sum_red_reg   <= '0;
                    sum_green_reg <= '0;
                    sum_blue_reg  <= '0;
                    sum_alpha_reg <= '0;
                end
                else
                begin
                    sum_red_reg   <= sum_red_reg + ptt_pkg::SUM_W'(term_red_reg);
                    sum_green_reg <= sum_green_reg + ptt_pkg::SUM_W'(term_green_reg);
                    sum_blue_reg  <= sum_blue_reg + ptt_pkg::SUM_W'(term_blue_reg);
                    sum_alpha_reg <= sum_alpha_reg + ptt_pkg::SUM_W'(term_alpha_reg);
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.sum_red   = sum_red_reg;
    assign rsp.sum_green = sum_green_reg;
    assign rsp.sum_blue  = sum_blue_reg;
    assign rsp.sum_alpha = sum_alpha_reg;

endmodule

>>> hdl/ptt_div.sv
// Shared radix-4 restoring divider with a saturating 16-bit quotient.
module ptt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ptt_pkg::div_req_t  req,
    output ptt_pkg::div_rsp_t  rsp
);

    localparam int          STEPS  = ptt_pkg::Q_W / 2;
    localparam int          CNT_W  = $clog2(STEPS);
    localparam logic [1:0]  PH_IDLE = 2'd0;
    localparam logic [1:0]  PH_PREP = 2'd1;
    localparam logic [1:0]  PH_STEP = 2'd2;

    logic [1:0]                 phase_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       done_reg;
    logic                       sat_reg;
    logic [ptt_pkg::SUM_W-1:0]  dividend_reg;
    logic [ptt_pkg::DIV_W-1:0]  divisor_reg;
    logic [ptt_pkg::DIV_W-1:0]  rem_reg;
    logic [ptt_pkg::Q_W-1:0]    low_reg;
    logic [ptt_pkg::Q_W-1:0]    quo_reg;

    logic [ptt_pkg::DIV_W:0]    trial1;
    logic [ptt_pkg::DIV_W:0]    trial2;
    logic [ptt_pkg::DIV_W:0]    diff1;
    logic [ptt_pkg::DIV_W:0]    diff2;
    logic                       ge1;
    logic                       ge2;
    logic [ptt_pkg::DIV_W-1:0]  rem1;
    logic [ptt_pkg::DIV_W-1:0]  rem2;

    // Two compare-subtract steps per cycle
    always_comb
    begin
        trial1 = {rem_reg, low_reg[ptt_pkg::Q_W-1]};
        ge1    = trial1 >= {1'b0, divisor_reg};
        diff1  = trial1 - {1'b0, divisor_reg};
        rem1   = ge1 ? diff1[ptt_pkg::DIV_W-1:0] : trial1[ptt_pkg::DIV_W-1:0];
        trial2 = {rem1, low_reg[ptt_pkg::Q_W-2]};
        ge2    = trial2 >= {1'b0, divisor_reg};
        diff2  = trial2 - {1'b0, divisor_reg};
        rem2   = ge2 ? diff2[ptt_pkg::DIV_W-1:0] : trial2[ptt_pkg::DIV_W-1:0];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        phase_reg <= PH_PREP;
                    end
                end
                PH_PREP:
                begin
                    cnt_reg   <= '0;
                    phase_reg <= PH_STEP;
                end
                PH_STEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // Datapath: capture operands, test for overflow, then shift out quotient bits
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && req.start)
        begin
            dividend_reg <= req.dividend;
            divisor_reg  <= req.divisor;
        end
        if (phase_reg == PH_PREP)
        begin
            sat_reg <= dividend_reg[ptt_pkg::SUM_W-1:ptt_pkg::Q_W] >=
                       (ptt_pkg::SUM_W-ptt_pkg::Q_W)'(divisor_reg);
            rem_reg <= dividend_reg[ptt_pkg::Q_W+ptt_pkg::DIV_W-1:ptt_pkg::Q_W];
            low_reg <= dividend_reg[ptt_pkg::Q_W-1:0];
        end
        if (phase_reg == PH_STEP)
        begin
            rem_reg <= rem2;
            low_reg <= {low_reg[ptt_pkg::Q_W-3:0], 2'b00};
            quo_reg <= {quo_reg[ptt_pkg::Q_W-3:0], ge1, ge2};
        end
    end

    assign rsp.busy     = phase_reg != PH_IDLE;
    assign rsp.done     = done_reg;
    assign rsp.quotient = sat_reg ? '1 : quo_reg;

endmodule

>>> tb/tb_preintegrated_transfer_table.sv
// Self-checking testbench for the pre-integrated transfer table.
module tb_preintegrated_transfer_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TAB_DEPTH     = 256;
    localparam int          SETTLE_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned CALM_FROM     = 1500;
    localparam int unsigned CALM_TO       = 4500;

    typedef struct packed {
        logic                        func;
        logic [ptt_pkg::IDX_W-1:0]   idx;
        logic [ptt_pkg::COLOR_W-1:0] red;
        logic [ptt_pkg::COLOR_W-1:0] green;
        logic [ptt_pkg::COLOR_W-1:0] blue;
        logic [ptt_pkg::OPAC_W-1:0]  opacity;
        logic [ptt_pkg::IDX_W-1:0]   front;
        logic [ptt_pkg::IDX_W-1:0]   back;
    } tf_item_t;

    typedef struct packed {
        logic [ptt_pkg::COLOR_W-1:0] red;
        logic [ptt_pkg::COLOR_W-1:0] green;
        logic [ptt_pkg::COLOR_W-1:0] blue;
        logic [ptt_pkg::OPAC_W-1:0]  opacity;
    } tf_entry_t;

    typedef struct packed {
        logic [ptt_pkg::Q_W-1:0] red;
        logic [ptt_pkg::Q_W-1:0] green;
        logic [ptt_pkg::Q_W-1:0] blue;
        logic [ptt_pkg::Q_W-1:0] alpha;
        logic                    status;
    } rgba_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_valid    = 1'b0;
    logic [ptt_pkg::CFG_W-1:0] cfg_data     = '0;
    logic                      item_valid   = 1'b0;
    logic                      result_stall = 1'b0;
    tf_item_t                  drv_item     = '0;
    logic                      item_fire    = 1'b0;

    logic                      cfg_ready;
    logic                      item_stall;
    logic                      result_valid;
    logic [ptt_pkg::Q_W-1:0]   out_red;
    logic [ptt_pkg::Q_W-1:0]   out_green;
    logic [ptt_pkg::Q_W-1:0]   out_blue;
    logic [ptt_pkg::Q_W-1:0]   out_alpha;
    logic                      status;

    // Pending input transactions and the RGBA answers still owed
    tf_item_t item_backlog[$];
    rgba_t    rgba_due[$];

    // Shadow of the block state
    logic [ptt_pkg::CFG_W-1:0] entries_cfg = ptt_pkg::CFG_RESET;
    logic [63:0]      pf_red[TAB_DEPTH];
    logic [63:0]      pf_green[TAB_DEPTH];
    logic [63:0]      pf_blue[TAB_DEPTH];
    logic [63:0]      pf_alpha[TAB_DEPTH];
    tf_entry_t        raw_tab[TAB_DEPTH];
    tf_entry_t        prev_entry = '0;
    logic [63:0]      run_red    = '0;
    logic [63:0]      run_green  = '0;
    logic [63:0]      run_blue   = '0;
    logic [63:0]      run_alpha  = '0;

    // Stimulus-side view of which entries hold data
    int unsigned gen_limit = TAB_DEPTH;
    bit          gen_loaded[TAB_DEPTH];

    int unsigned cyc        = 0;
    int unsigned mismatches = 0;

    preintegrated_transfer_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (drv_item.func),
        .entry_index  (drv_item.idx),
        .entry_red    (drv_item.red),
        .entry_green  (drv_item.green),
        .entry_blue   (drv_item.blue),
        .entry_opacity(drv_item.opacity),
        .front_index  (drv_item.front),
        .back_index   (drv_item.back),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .status       (status)
    );

    always #4 clk = ~clk;

    // Trapezoid step of opacity-weighted colour between two neighbouring entries
    function automatic logic [63:0] trap_term(input logic [63:0] a0, input logic [63:0] c0,
                                              input logic [63:0] a1, input logic [63:0] c1);
        return (a1 + a0) * (c1 + c0) + a1 * c1 + a0 * c0;
    endfunction

    // Floored prefix difference over a divisor, clamped at zero and at full scale
    function automatic logic [ptt_pkg::Q_W-1:0] seg_quot(input logic [63:0] lo_sum,
                                                         input logic [63:0] hi_sum,
                                                         input logic [63:0] divisor);
        logic [63:0] q;
        if (hi_sum < lo_sum)
            return '0;
        q = (hi_sum - lo_sum) / divisor;
        return (q > 64'd65535) ? 16'hFFFF : q[ptt_pkg::Q_W-1:0];
    endfunction

    // Apply one accepted transaction to the shadow state; queue the answer of a query
    function automatic void integrate_item(input tf_item_t it);
        int unsigned               lim;
        logic [ptt_pkg::IDX_W-1:0] lo;
        logic [ptt_pkg::IDX_W-1:0] hi;
        logic [63:0]               span_len;
        tf_entry_t                 ent;
        rgba_t                     res;
        lim = (entries_cfg < TAB_DEPTH) ? entries_cfg : TAB_DEPTH;
        res = '0;
        if (it.func == ptt_pkg::FUNC_LOAD)
        begin
            if (it.idx >= lim)
                return;
            ent = '{red: it.red, green: it.green, blue: it.blue, opacity: it.opacity};
            if (it.idx == 0)
            begin
                run_red   = '0;
                run_green = '0;
                run_blue  = '0;
                run_alpha = '0;
            end
            else
            begin
                run_red   += trap_term(64'(prev_entry.opacity), 64'(prev_entry.red),
                                       64'(ent.opacity), 64'(ent.red));
                run_green += trap_term(64'(prev_entry.opacity), 64'(prev_entry.green),
                                       64'(ent.opacity), 64'(ent.green));
                run_blue  += trap_term(64'(prev_entry.opacity), 64'(prev_entry.blue),
                                       64'(ent.opacity), 64'(ent.blue));
                run_alpha += 64'(prev_entry.opacity) + 64'(ent.opacity);
            end
            pf_red[it.idx]   = run_red;
            pf_green[it.idx] = run_green;
            pf_blue[it.idx]  = run_blue;
            pf_alpha[it.idx] = run_alpha;
            raw_tab[it.idx]  = ent;
            prev_entry       = ent;
            return;
        end
        if (it.front >= lim || it.back >= lim)
        begin
            res.status = 1'b1;
        end
        else if (it.front == it.back)
        begin
            ent       = raw_tab[it.front];
            res.red   = ptt_pkg::Q_W'((32'(ent.opacity) * ent.red) / 255);
            res.green = ptt_pkg::Q_W'((32'(ent.opacity) * ent.green) / 255);
            res.blue  = ptt_pkg::Q_W'((32'(ent.opacity) * ent.blue) / 255);
            res.alpha = ent.opacity;
        end
        else
        begin
            lo        = (it.front < it.back) ? it.front : it.back;
            hi        = (it.front < it.back) ? it.back : it.front;
            span_len  = 64'(hi - lo);
            res.red   = seg_quot(pf_red[lo], pf_red[hi], 6 * 255 * span_len);
            res.green = seg_quot(pf_green[lo], pf_green[hi], 6 * 255 * span_len);
            res.blue  = seg_quot(pf_blue[lo], pf_blue[hi], 6 * 255 * span_len);
            res.alpha = seg_quot(pf_alpha[lo], pf_alpha[hi], 2 * span_len);
        end
        rgba_due.push_back(res);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic bit idle_roll();
        return !(cyc >= CALM_FROM && cyc < CALM_TO) && ($urandom_range(0, 99) < 9);
    endfunction

    // Stimulus builders
    function automatic void queue_load(input int unsigned idx, input int unsigned r,
                                       input int unsigned g, input int unsigned b,
                                       input int unsigned a);
        tf_item_t it;
        it         = '0;
        it.func    = ptt_pkg::FUNC_LOAD;
        it.idx     = ptt_pkg::IDX_W'(idx);
        it.red     = ptt_pkg::COLOR_W'(r);
        it.green   = ptt_pkg::COLOR_W'(g);
        it.blue    = ptt_pkg::COLOR_W'(b);
        it.opacity = ptt_pkg::OPAC_W'(a);
        it.front   = ptt_pkg::IDX_W'($urandom);
        it.back    = ptt_pkg::IDX_W'($urandom);
        item_backlog.push_back(it);
        if (idx < gen_limit)
            gen_loaded[ptt_pkg::IDX_W'(idx)] = 1'b1;
    endfunction

    function automatic void queue_query(input int unsigned f, input int unsigned b);
        tf_item_t it;
        it         = '0;
        it.func    = ptt_pkg::FUNC_QUERY;
        it.idx     = ptt_pkg::IDX_W'($urandom);
        it.red     = ptt_pkg::COLOR_W'($urandom);
        it.green   = ptt_pkg::COLOR_W'($urandom);
        it.blue    = ptt_pkg::COLOR_W'($urandom);
        it.opacity = ptt_pkg::OPAC_W'($urandom);
        it.front   = ptt_pkg::IDX_W'(f);
        it.back    = ptt_pkg::IDX_W'(b);
        item_backlog.push_back(it);
    endfunction

    function automatic void queue_rand_load(input int unsigned idx);
        int unsigned a;
        case ($urandom_range(0, 7))
            0:       a = 0;
            1:       a = 65535;
            default: a = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 7) == 0)
            queue_load(idx, 255, 255, 255, a);
        else
            queue_load(idx, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), a);
    endfunction

    function automatic int unsigned pick_loaded();
        int unsigned i;
        do
            i = $urandom_range(0, gen_limit - 1);
        while (!gen_loaded[ptt_pkg::IDX_W'(i)]);
        return i;
    endfunction

    // Query two loaded entries, now and then the same one twice
    function automatic void queue_rand_query();
        int unsigned f;
        f = pick_loaded();
        if ($urandom_range(0, 6) == 0)
            queue_query(f, f);
        else
            queue_query(f, pick_loaded());
    endfunction

    // Mostly in-order sweeps with queries; the rest reloads, restarts and
    // out-of-range transactions
    function automatic void random_phase(input int unsigned n);
        int unsigned cnt;
        int unsigned pos;
        int unsigned r;
        cnt = 0;
        pos = 0;
        while (cnt < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                queue_rand_load(pos);
                pos = (pos + 1 >= gen_limit) ? 0 : pos + 1;
                cnt++;
            end
            else if (r < 80)
            begin
                queue_rand_query();
                cnt++;
            end
            else if (r < 88)
            begin
                queue_rand_load($urandom_range(0, gen_limit - 1));
                cnt++;
            end
            else if (r < 94)
            begin
                if (gen_limit < TAB_DEPTH)
                begin
                    queue_rand_load($urandom_range(gen_limit, TAB_DEPTH - 1));
                end
                else
                begin
                    queue_rand_load(0);
                    pos = 1;
                    cnt++;
                end
            end
            else
            begin
                if (gen_limit < TAB_DEPTH)
                    queue_query($urandom_range(0, TAB_DEPTH - 1),
                                $urandom_range(gen_limit, TAB_DEPTH - 1));
                else
                    queue_rand_query();
                cnt++;
            end
        end
    endfunction

    // Wait until every transaction is taken and every answer has come, then let
    // the block finish any load still in flight
    task automatic settle();
        while (item_backlog.size() != 0 || item_valid || rgba_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entries(input int unsigned v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ptt_pkg::CFG_W'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        gen_limit = (v < TAB_DEPTH) ? v : TAB_DEPTH;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drive input transactions and the result stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_fire)
            begin
                if (item_backlog.size() != 0 && !idle_roll())
                begin
                    drv_item   <= item_backlog.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
            result_stall <= idle_roll();
        end
    end

    // Check answers, track accepted transactions and configuration, watch the clock
    always @(posedge clk)
    begin
        rgba_t want;
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("tb_preintegrated_transfer_table: done, errors");
            $finish;
        end
        if (result_valid && !result_stall)
        begin
            if (rgba_due.size() == 0)
            begin
                $error("unexpected result transaction");
                mismatches++;
            end
            else
            begin
                want = rgba_due.pop_front();
                check_field("out_red", 32'(want.red), 32'(out_red));
                check_field("out_green", 32'(want.green), 32'(out_green));
                check_field("out_blue", 32'(want.blue), 32'(out_blue));
                check_field("out_alpha", 32'(want.alpha), 32'(out_alpha));
                check_field("status", 32'(want.status), 32'(status));
            end
        end
        if (cfg_valid && cfg_ready)
            entries_cfg <= cfg_data;
        item_fire <= item_valid && !item_stall;
        if (item_valid && !item_stall)
            integrate_item(drv_item);
    end

    initial
    begin
        int unsigned mid_cfg;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, equal ends, reversed ends, reload and restart
        write_entries(256);
        queue_load(0, 255, 0, 128, 65535);
        queue_load(1, 0, 255, 255, 0);
        queue_load(2, 255, 255, 255, 65535);
        queue_load(3, 0, 0, 0, 32768);
        queue_query(0, 0);
        queue_query(2, 2);
        queue_query(1, 1);
        queue_query(3, 3);
        queue_query(0, 3);
        queue_query(3, 0);
        queue_query(1, 2);
        queue_query(0, 1);
        // reload behind the last entry: the sum at 1 overtakes the one at 2
        queue_load(1, 255, 255, 255, 65535);
        queue_query(0, 1);
        queue_query(1, 2);
        queue_load(0, 17, 34, 51, 1000);
        queue_query(0, 0);
        settle();

        // Full in-order sweep of the table, holding off once half way
        for (int i = 0; i < TAB_DEPTH; i++)
        begin
            queue_rand_load(i);
            if ($urandom_range(0, 99) < 15)
                queue_rand_query();
            if (i == TAB_DEPTH / 2 - 1)
                settle();
        end
        queue_query(0, 255);
        queue_query(255, 0);
        queue_query(255, 255);
        settle();

        // Smallest table: out-of-range queries and ignored loads
        write_entries(2);
        queue_query(0, 255);
        queue_query(255, 0);
        queue_query(200, 200);
        queue_query(2, 1);
        queue_query(0, 1);
        queue_rand_load(255);
        queue_rand_load(2);
        queue_rand_load(1);
        queue_query(0, 1);
        queue_query(1, 1);
        random_phase(15);
        settle();

        mid_cfg = $urandom_range(3, 255);
        write_entries(mid_cfg);
        random_phase(30);
        settle();

        write_entries(256);
        random_phase(20);
        settle();

        write_entries(255);
        queue_query(255, 0);
        random_phase(15);
        settle();

        if (mismatches == 0)
            $display("tb_preintegrated_transfer_table: done, clean");
        else
            $display("tb_preintegrated_transfer_table: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ptt_pkg.sv
hdl/ptt_ram.sv
hdl/ptt_load.sv
hdl/ptt_div.sv
hdl/preintegrated_transfer_table.sv
tb/tb_preintegrated_transfer_table.sv
